// ===== sv/bfa_pkg.sv =====
// Shared types and constants of the box filter core.
package bfa_pkg;

   localparam int CH_W   = 8;
   localparam int NUM_CH = 3;
   localparam int FW_W   = 11;
   localparam int FH_W   = 12;

   // element 0 is red, 1 green, 2 blue (red in the lowest bits)
   typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_type;

   typedef enum logic {
      ACT_PIXEL = 1'b0,
      ACT_FLUSH = 1'b1
   } action_type;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CW    = 4;
   localparam int INFLIGHT_W = 3;

   typedef struct packed {
      logic emit;
      logic take;
      logic interior;
      logic last;
   } beat_ctrl_type;

   typedef struct packed {
      rgb_type pixel;
      logic    last;
   } result_type;

endpackage

// ===== sv/bfa_line_store.sv =====
// Line store: one word per column, one lane per ring line, two registered read ports.
module bfa_line_store #(
   parameter int DEPTH = 1024,
   parameter int LANES = 3
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [$clog2(LANES)-1:0]          wr_lane,
   input  bfa_pkg::rgb_type                  wr_pixel,
   input  logic [$clog2(DEPTH)-1:0]          rd_a_addr,
   output bfa_pkg::rgb_type [LANES-1:0]      rd_a_q,
   input  logic [$clog2(DEPTH)-1:0]          rd_b_addr,
   input  logic [$clog2(LANES)-1:0]          rd_b_lane,
   output bfa_pkg::rgb_type                  rd_b_q
);

   bfa_pkg::rgb_type [LANES-1:0] store_ff [DEPTH];
   bfa_pkg::rgb_type [LANES-1:0] rd_a_q_ff;
   bfa_pkg::rgb_type             rd_b_q_ff;

   // reads return the word as it was before a write at the same edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr][wr_lane] <= wr_pixel;
      end
      rd_a_q_ff <= store_ff[rd_a_addr];
      rd_b_q_ff <= store_ff[rd_b_addr][rd_b_lane];
   end

   assign rd_a_q = rd_a_q_ff;
   assign rd_b_q = rd_b_q_ff;

endmodule

// ===== sv/bfa_mean.sv =====
// Window mean pipeline: column sums, window sum, reciprocal multiply, pass-through select.
module bfa_mean #(
   parameter int RADIUS = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  bfa_pkg::beat_ctrl_type                  s0_ctrl,
   input  bfa_pkg::rgb_type                        s0_pixel,
   input  logic [$clog2(2*RADIUS+1)-1:0]           s0_lane,
   input  bfa_pkg::rgb_type [2*RADIUS:0]           col_word,
   input  bfa_pkg::rgb_type                        centre_pixel,
   output logic                                    out_valid,
   output bfa_pkg::result_type                     out_result,
   output logic [bfa_pkg::INFLIGHT_W-1:0]          inflight
);

   localparam int RL          = 2*RADIUS + 1;
   localparam int LANE_W      = $clog2(RL);
   localparam int WIN_AREA    = RL * RL;
   localparam int COL_SUM_W   = $clog2(RL * 255 + 1);
   localparam int SUM_W       = $clog2(WIN_AREA * 255 + 1);
   localparam int RECIP_SHIFT = 2*SUM_W - 7;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + WIN_AREA - 1) / WIN_AREA;
   localparam int PROD_W      = RECIP_SHIFT + bfa_pkg::CH_W;

   bfa_pkg::beat_ctrl_type s1_ctrl_ff, s2_ctrl_ff, s3_ctrl_ff, s4_ctrl_ff;
   bfa_pkg::rgb_type       s1_pixel_ff;
   logic [LANE_W-1:0]      s1_lane_ff;
   bfa_pkg::rgb_type       s2_pass_ff, s3_pass_ff, s4_pass_ff;

   logic [COL_SUM_W-1:0]   colsum_new [bfa_pkg::NUM_CH];
   logic [COL_SUM_W-1:0]   colsum_ff  [RL][bfa_pkg::NUM_CH];
   logic [COL_SUM_W-1:0]   colsum_in  [RL][bfa_pkg::NUM_CH];
   logic [SUM_W-1:0]       s3_sum_in  [bfa_pkg::NUM_CH];
   logic [SUM_W-1:0]       s3_sum_ff  [bfa_pkg::NUM_CH];
   logic [PROD_W-1:0]      s4_prod_in [bfa_pkg::NUM_CH];
   logic [PROD_W-1:0]      s4_prod_ff [bfa_pkg::NUM_CH];

   // column of the new pixel: the other ring lanes hold the 2R lines above it
   always_comb begin
      for (int ch = 0; ch < bfa_pkg::NUM_CH; ch++) begin
         colsum_new[ch] = COL_SUM_W'(s1_pixel_ff[ch]);
         for (int k = 0; k < RL; k++) begin
            if (LANE_W'(k) != s1_lane_ff) begin
               colsum_new[ch] = colsum_new[ch] + COL_SUM_W'(col_word[k][ch]);
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < RL; k++) begin
         for (int ch = 0; ch < bfa_pkg::NUM_CH; ch++) begin
            if (!s1_ctrl_ff.take) begin
               colsum_in[k][ch] = colsum_ff[k][ch];
            end else if (k == 0) begin
               colsum_in[k][ch] = colsum_new[ch];
            end else begin
               colsum_in[k][ch] = colsum_ff[k-1][ch];
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < bfa_pkg::NUM_CH; ch++) begin
         s3_sum_in[ch] = '0;
         for (int k = 0; k < RL; k++) begin
            s3_sum_in[ch] = s3_sum_in[ch] + SUM_W'(colsum_ff[k][ch]);
         end
         s4_prod_in[ch] = PROD_W'(s3_sum_ff[ch]) * PROD_W'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
         s3_ctrl_ff <= '0;
         s4_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= s0_ctrl;
         s2_ctrl_ff <= s1_ctrl_ff;
         s3_ctrl_ff <= s2_ctrl_ff;
         s4_ctrl_ff <= s3_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff <= s0_pixel;
      s1_lane_ff  <= s0_lane;
      s2_pass_ff  <= centre_pixel;
      s3_pass_ff  <= s2_pass_ff;
      s4_pass_ff  <= s3_pass_ff;
      colsum_ff   <= colsum_in;
      s3_sum_ff   <= s3_sum_in;
      s4_prod_ff  <= s4_prod_in;
   end

   always_comb begin
      out_valid       = s4_ctrl_ff.emit;
      out_result.last = s4_ctrl_ff.last;
      for (int ch = 0; ch < bfa_pkg::NUM_CH; ch++) begin
         if (s4_ctrl_ff.interior) begin
            out_result.pixel[ch] = s4_prod_ff[ch][RECIP_SHIFT +: bfa_pkg::CH_W];
         end else begin
            out_result.pixel[ch] = s4_pass_ff[ch];
         end
      end
   end

   assign inflight = bfa_pkg::INFLIGHT_W'(s1_ctrl_ff.emit) + bfa_pkg::INFLIGHT_W'(s2_ctrl_ff.emit)
                   + bfa_pkg::INFLIGHT_W'(s3_ctrl_ff.emit) + bfa_pkg::INFLIGHT_W'(s4_ctrl_ff.emit);

endmodule

// ===== sv/bfa_out_fifo.sv =====
// Result queue between the mean pipeline and the rsp channel.
module bfa_out_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  bfa_pkg::result_type             push_data,
   input  logic                            pop,
   output logic                            out_valid,
   output bfa_pkg::result_type             out_data,
   output logic [bfa_pkg::FIFO_CW-1:0]     level
);

   bfa_pkg::result_type             entries_ff [bfa_pkg::FIFO_DEPTH];
   logic [bfa_pkg::FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bfa_pkg::FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bfa_pkg::FIFO_CW-1:0]     count_ff, count_in;
   logic                            do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign level     = count_ff;

endmodule

// ===== sv/box_filter_antialias_core.sv =====
// Box mean filter core: raster RGB in, filtered or passed-through RGB out.
//
// req_*: one beat per pixel (tuser = 0) or flush tick (tuser = 1), tdata = red, green,
// blue from bit 0 up. Each pixel beat of a frame, once R lines plus R pixels have
// arrived, releases the output pixel that far behind it; after the frame's last pixel,
// one flush beat releases each remaining output. rsp_* carries the pixels in raster
// order, tlast marking the frame's last one. csr_* writes frame width (index 0) and
// height (index 1); the size in use is taken when a frame's first pixel arrives.
// Throughput is one beat per cycle while req_tready is high: the line store is read for
// the column and written with the new pixel in the same cycle. A released result passes
// through the memory read, column sum, window sum and reciprocal multiply registers and
// then an 8-entry result queue before it reaches rsp; the queue absorbs receiver stalls,
// and req_tready drops only when the queue plus the results still in the pipeline could
// fill it. Reset clears all counters and sets the size to 640 x 480; the line store is
// not cleared, as every stored pixel that reaches an output is from the current frame.
module box_filter_antialias_core #(
   parameter int WINDOW_RADIUS  = 1,
   parameter int MAX_LINE_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in, green_in, blue_in
   input  logic [0:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red_out, green_out, blue_out
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int RL        = 2*WINDOW_RADIUS + 1;
   localparam int LANE_W    = $clog2(RL);
   localparam int COL_W     = $clog2(MAX_LINE_WIDTH);
   localparam int FW_W      = bfa_pkg::FW_W;
   localparam int FH_W      = bfa_pkg::FH_W;
   localparam int WIDTH_CAP = (MAX_LINE_WIDTH < 2047) ? MAX_LINE_WIDTH : 2047;
   localparam int CW        = ((COL_W > FW_W) ? COL_W : FW_W) + 1;
   localparam int RW        = FH_W + 1;
   localparam int LAG_W     = $clog2(WINDOW_RADIUS*WIDTH_CAP + WINDOW_RADIUS + 1);
   localparam int LW        = bfa_pkg::FIFO_CW + 1;
   localparam logic [FW_W-1:0] W_CAP = FW_W'(WIDTH_CAP);

   logic [FW_W-1:0]   width_ff, width_in, act_w_ff, act_w_in;
   logic [FH_W-1:0]   height_ff, height_in, act_h_ff, act_h_in;
   logic [COL_W-1:0]  col_ff, col_in, out_col_ff, out_col_in;
   logic [FH_W-1:0]   row_ff, row_in, out_row_ff, out_row_in;
   logic [LANE_W-1:0] in_lane_ff, in_lane_in, out_lane_ff, out_lane_in;
   logic [LAG_W-1:0]  lag_cnt_ff, lag_cnt_in;

   logic [FW_W-1:0]   clamp_w, eff_w;
   logic [FH_W-1:0]   clamp_h, eff_h;
   logic [LAG_W-1:0]  lag;
   logic              accept, is_pix, latch, take, emit, interior, out_last;
   logic              in_col_last, out_col_last;

   bfa_pkg::beat_ctrl_type              s0_ctrl;
   bfa_pkg::rgb_type [RL-1:0]           col_word;
   bfa_pkg::rgb_type                    centre_pixel;
   logic                                mean_valid;
   bfa_pkg::result_type                 mean_result, fifo_data;
   logic [bfa_pkg::INFLIGHT_W-1:0]      inflight;
   logic [bfa_pkg::FIFO_CW-1:0]         fifo_level;

   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign is_pix     = (req_tuser[0] == bfa_pkg::ACT_PIXEL);
   assign req_tready = (LW'(fifo_level) + LW'(inflight)) < LW'(bfa_pkg::FIFO_DEPTH);

   always_comb begin
      clamp_w = width_ff;
      if (width_ff == '0) begin
         clamp_w = FW_W'(1);
      end else if (width_ff > W_CAP) begin
         clamp_w = W_CAP;
      end
      clamp_h = (height_ff == '0) ? FH_W'(1) : height_ff;

      latch = accept && is_pix && (col_ff == '0) && (row_ff == '0)
            && (out_col_ff == '0) && (out_row_ff == '0);
      eff_w = latch ? clamp_w : act_w_ff;
      eff_h = latch ? clamp_h : act_h_ff;
      lag   = LAG_W'(WINDOW_RADIUS * eff_w + WINDOW_RADIUS);

      take         = accept && is_pix && (row_ff < eff_h);
      in_col_last  = CW'(col_ff) == CW'(eff_w - FW_W'(1));
      out_col_last = CW'(out_col_ff) == CW'(eff_w - FW_W'(1));
      emit         = (take && (lag_cnt_ff >= lag))
                   || (accept && !is_pix && (row_ff >= act_h_ff));
      interior     = (RW'(out_row_ff) >= RW'(WINDOW_RADIUS))
                   && (RW'(out_row_ff) + RW'(WINDOW_RADIUS) < RW'(eff_h))
                   && (CW'(out_col_ff) >= CW'(WINDOW_RADIUS))
                   && (CW'(out_col_ff) + CW'(WINDOW_RADIUS) < CW'(eff_w));
      out_last     = (out_row_ff == eff_h - FH_W'(1)) && out_col_last;
   end

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      act_w_in    = eff_w;
      act_h_in    = eff_h;
      col_in      = col_ff;
      row_in      = row_ff;
      in_lane_in  = in_lane_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_lane_in = out_lane_ff;
      lag_cnt_in  = lag_cnt_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == bfa_pkg::REG_FRAME_WIDTH) begin
            width_in = csr_wdata[FW_W-1:0];
         end else begin
            height_in = csr_wdata;
         end
      end

      if (take) begin
         if (lag_cnt_ff < lag) begin
            lag_cnt_in = lag_cnt_ff + 1'b1;
         end
         if (in_col_last) begin
            col_in     = '0;
            row_in     = row_ff + 1'b1;
            in_lane_in = (in_lane_ff == LANE_W'(RL-1)) ? '0 : in_lane_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end

      if (emit) begin
         if (out_col_last) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + 1'b1;
            out_lane_in = (out_lane_ff == LANE_W'(RL-1)) ? '0 : out_lane_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
         // frame complete: back to the start for the next frame
         if (out_last) begin
            col_in      = '0;
            row_in      = '0;
            in_lane_in  = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            out_lane_in = '0;
            lag_cnt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= bfa_pkg::FRAME_WIDTH_RESET;
         height_ff   <= bfa_pkg::FRAME_HEIGHT_RESET;
         act_w_ff    <= bfa_pkg::FRAME_WIDTH_RESET;
         act_h_ff    <= bfa_pkg::FRAME_HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         in_lane_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_lane_ff <= '0;
         lag_cnt_ff  <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         act_w_ff    <= act_w_in;
         act_h_ff    <= act_h_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         in_lane_ff  <= in_lane_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_lane_ff <= out_lane_in;
         lag_cnt_ff  <= lag_cnt_in;
      end
   end

   always_comb begin
      s0_ctrl.emit     = emit;
      s0_ctrl.take     = take;
      s0_ctrl.interior = interior;
      s0_ctrl.last     = out_last;
   end

   bfa_line_store #(
      .DEPTH (MAX_LINE_WIDTH),
      .LANES (RL)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (take),
      .wr_addr   (col_ff),
      .wr_lane   (in_lane_ff),
      .wr_pixel  (req_tdata),
      .rd_a_addr (col_ff),
      .rd_a_q    (col_word),
      .rd_b_addr (out_col_ff),
      .rd_b_lane (out_lane_ff),
      .rd_b_q    (centre_pixel)
   );

   bfa_mean #(
      .RADIUS (WINDOW_RADIUS)
   ) u_mean (
      .clock        (clock),
      .reset        (reset),
      .s0_ctrl      (s0_ctrl),
      .s0_pixel     (req_tdata),
      .s0_lane      (in_lane_ff),
      .col_word     (col_word),
      .centre_pixel (centre_pixel),
      .out_valid    (mean_valid),
      .out_result   (mean_result),
      .inflight     (inflight)
   );

   bfa_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mean_valid),
      .push_data (mean_result),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (fifo_data),
      .level     (fifo_level)
   );

   assign rsp_tdata = fifo_data.pixel;
   assign rsp_tlast = fifo_data.last;

endmodule
